// File: rtl/assert_macros.svh
// Assertion helpers for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/qenc_pkg.sv
package qenc_pkg;

  // Field widths of the input and result items, the config registers and the accumulator.
  localparam int TimeW  = 32;
  localparam int CountW = 16;
  localparam int DeltaW = 9;
  localparam int PauseW = 24;
  localparam int StepW  = 8;
  localparam int AccW   = 4;

  // Packed stream widths, rounded up to whole bytes.
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  // Configuration port.
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 24;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PAUSE_LENGTH_US = 1'b0,
    REG_FAST_STEP       = 1'b1
  } cfg_reg_t;

  localparam logic [PauseW-1:0] PauseReset = 24'd25000;
  localparam logic [StepW-1:0]  FastReset  = 8'd10;

  // Both pins high after reset.
  localparam logic [1:0] AbReset = 2'b11;

  // Detent thresholds on the quarter-step accumulator.
  localparam logic signed [AccW-1:0] AccUpLimit   = 4'sd3;
  localparam logic signed [AccW-1:0] AccDownLimit = -4'sd3;

  localparam logic signed [CountW:0] CountMax = 17'sd32767;
  localparam logic signed [CountW:0] CountMin = -17'sd32768;

  // Quarter-step value for the pair {previous AB, current AB}.
  // Illegal two-bit jumps and no change both count zero.
  function automatic logic signed [1:0] step_value(input logic [3:0] idx);
    logic signed [1:0] v;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: v = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: v = 2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/quadrature_encoder_with_acceleration.sv
// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   40     pin_a, pin_b, time_us[31:0], clear_count
// m_axis    out  32     count[15:0], delta[8:0]
// cfg       in   24     0: pause_length_us, 1: fast_step
//
// One item per clock unless the output stalls: the table lookup, timestamp
// compare and saturating add sit in one combinational pass between the input
// port and the result register. Results are registered in the result register, or
// while the output stalls in a skid register, which keeps s_tready high for one more item.
// rst is synchronous and restores the config registers, encoder state and valid flags.
`include "assert_macros.svh"

module quadrature_encoder_with_acceleration (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pin_a, pin_b, time_us[31:0], clear_count, zero fill
  input  logic [qenc_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // count[15:0], delta[8:0], zero fill
  output logic [qenc_pkg::OutDataW-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [qenc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [qenc_pkg::CfgDataW-1:0]  cfg_data
);
  import qenc_pkg::*;

  // Configuration registers.
  logic [PauseW-1:0] pause_length_us;
  logic [StepW-1:0]  fast_step;

  // Encoder state.
  logic [1:0]                previous_ab;
  logic signed [AccW-1:0]    step_acc;
  logic [TimeW-1:0]          last_up_time;
  logic [TimeW-1:0]          last_down_time;
  logic signed [CountW-1:0]  position;

  // Result register and skid register.
  logic                     skid_valid;
  logic [OutDataW-1:0]      skid_data;

  // Next-state values.
  logic signed [AccW-1:0]    step_acc_next;
  logic signed [CountW-1:0]  position_next;
  logic [OutDataW-1:0]       result;

  logic                     s_fire;
  logic                     in_a, in_b, in_clear;
  logic [TimeW-1:0]         in_time;
  logic [1:0]               cur_ab;
  logic signed [AccW-1:0]   acc_sum;
  logic                     move_up, move_down;
  logic [TimeW-1:0]         elapsed;
  logic                     fast;
  logic signed [DeltaW-1:0] change;
  logic signed [CountW-1:0] base;
  logic signed [CountW:0]   sum;
  logic signed [DeltaW-1:0] delta;

  assign s_tready = ~skid_valid;
  assign s_fire   = s_tvalid & s_tready;

  // Unpack the input item.
  assign in_a     = s_tdata[0];
  assign in_b     = s_tdata[1];
  assign in_time  = s_tdata[TimeW+1:2];
  assign in_clear = s_tdata[TimeW+2];
  assign cur_ab   = {in_a, in_b};

  // Decode one sample: quarter steps, detent detection, fast check, clear, saturation.
  always_comb begin
    acc_sum   = step_acc + AccW'(step_value({previous_ab, cur_ab}));
    move_up   = acc_sum > AccUpLimit;
    move_down = acc_sum < AccDownLimit;
    elapsed   = move_up ? (in_time - last_up_time) : (in_time - last_down_time);
    fast      = elapsed < {{(TimeW-PauseW){1'b0}}, pause_length_us};
    change    = '0;
    if (move_up) begin
      change = fast ? $signed({1'b0, fast_step}) : DeltaW'(1);
    end else if (move_down) begin
      change = fast ? -$signed({1'b0, fast_step}) : -DeltaW'(1);
    end
    step_acc_next = (move_up | move_down) ? '0 : acc_sum;
    base = in_clear ? '0 : position;
    sum  = CountW'(base) + (CountW+1)'(change);
    if (sum > CountMax) begin
      position_next = CountW'(CountMax);
    end else if (sum < CountMin) begin
      position_next = CountW'(CountMin);
    end else begin
      position_next = CountW'(sum);
    end
    delta  = DeltaW'(position_next - base);
    result = {{(OutDataW-CountW-DeltaW){1'b0}}, delta, position_next};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_length_us <= PauseReset;
      fast_step       <= FastReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAUSE_LENGTH_US: pause_length_us <= cfg_data[PauseW-1:0];
        REG_FAST_STEP:       fast_step       <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Encoder state advances with every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab    <= AbReset;
      step_acc       <= '0;
      last_up_time   <= '0;
      last_down_time <= '0;
      position       <= '0;
    end else if (s_fire) begin
      previous_ab <= cur_ab;
      step_acc    <= step_acc_next;
      position    <= position_next;
      if (move_up) begin
        last_up_time <= in_time;
      end
      if (move_down) begin
        last_down_time <= in_time;
      end
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= s_fire;
        end
      end else if (s_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (s_fire) begin
        m_tdata <= result;
      end
    end
    if (s_fire && m_tvalid && !m_tready) begin
      skid_data <= result;
    end
  end

  // A waiting skid item always has a result ahead of it.
  `ASSERT_CLK(a_skid_behind_main, skid_valid |-> m_tvalid, "skid holds an item with no result ahead")
  // The accumulator is cleared at each detent, so it stays within three steps.
  `ASSERT_CLK(a_acc_range, (step_acc <= AccUpLimit) && (step_acc >= AccDownLimit), "step accumulator out of range")
  // After an accepted item, a result is always valid in the next cycle.
  `ASSERT_CLK(a_fire_gives_result, s_fire |=> m_tvalid, "accepted item produced no result")
  // A detent move never leaves the accumulator nonzero.
  `ASSERT_CLK(a_detent_clears, (s_fire && (move_up || move_down)) |=> (step_acc == '0), "accumulator not cleared after detent")

endmodule
